FILE: hdl/jet_pkg.sv
package jet_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_AREA_LEFT      = 3'd0;
  localparam logic [2:0] REG_AREA_TOP       = 3'd1;
  localparam logic [2:0] REG_AREA_WIDTH     = 3'd2;
  localparam logic [2:0] REG_AREA_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_CONST_RE       = 3'd4;
  localparam logic [2:0] REG_CONST_IM       = 3'd5;
  localparam logic [2:0] REG_MAX_ITERATIONS = 3'd6;
  localparam logic [2:0] REG_COLOR_CHANNEL  = 3'd7;

  // Reset values; c defaults to -0.4 + 0.6i in Q4.28
  localparam logic [12:0] AREA_WIDTH_RESET  = 13'd640;
  localparam logic [12:0] AREA_HEIGHT_RESET = 13'd480;
  localparam logic [31:0] CONST_RE_RESET    = 32'hF999_999A;
  localparam logic [31:0] CONST_IM_RESET    = 32'h0999_999A;
  localparam logic [15:0] MAX_ITER_RESET    = 16'd1000;

  // Channel selector codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_SHADE
  } div_sel_t;

  typedef struct packed {
    logic [11:0] area_left;
    logic [11:0] area_top;
    logic [12:0] area_width;
    logic [12:0] area_height;
    logic [31:0] const_re;
    logic [31:0] const_im;
    logic [15:0] max_iterations;
    logic [1:0]  color_channel;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_x;
    logic     store_y;
    logic     mul;
    logic     sum;
    logic     step;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic at_limit;
    logic escape;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hdl/jet_div.sv
module jet_div #(
  parameter int DW = 43,
  parameter int VW = 16,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient,
  output logic          overflow
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [VW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, dvd[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
      overflow <= 1'b0;
    end else if (busy) begin
      dvd      <= dvd << 1;
      rem      <= fits ? VW'(trial - {1'b0, dvs}) : VW'(trial);
      quotient <= {quotient[QW-2:0], fits};
      // any bit pushed out of the top means the quotient does not fit
      overflow <= overflow | quotient[QW-1];
    end
  end

endmodule

FILE: hdl/jet_datapath.sv
module jet_datapath #(
  parameter int FB = 28,
  parameter int CB = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [12:0]         in_x,
  input  logic [12:0]         in_y,
  input  jet_pkg::cfg_t       cfg,
  input  jet_pkg::dp_cmd_t    cmd,
  output jet_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [12:0]         out_x,
  output logic [12:0]         out_y,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue
);

  import jet_pkg::*;

  localparam int W   = FB + 4;
  localparam int H   = (W + 1) / 2;
  localparam int N   = W + 6;
  localparam int DW  = (FB + 15 > CB + 8) ? FB + 15 : CB + 8;
  localparam int VW  = (CB > 13) ? CB : 13;
  localparam int LW  = (CB > 16) ? CB : 16;
  localparam int UP  = (FB >= 28) ? FB - 28 : 0;
  localparam int DN  = (FB < 28) ? 28 - FB : 0;
  localparam int CW2 = W + DN;

  localparam logic signed [N-1:0] HI_N = $signed({{(N-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [N-1:0] LO_N = $signed({{(N-W+1){1'b1}}, {(W-1){1'b0}}});
  localparam logic signed [W-1:0] WHI  = W'(HI_N);
  localparam logic signed [W-1:0] WLO  = W'(LO_N);
  localparam logic signed [N-1:0] TWO_N = $signed(N'(1) << (FB + 1));
  localparam logic [2*W:0]        FOUR  = (2*W+1)'(1) << (2*FB + 2);
  localparam logic [CB-1:0]       CMAX  = '1;

  typedef logic [3:0][2*H-1:0] pp_t;

  function automatic logic signed [W-1:0] sat_n(input logic signed [N-1:0] v);
    if (v > HI_N) begin
      return WHI;
    end else if (v < LO_N) begin
      return WLO;
    end
    return W'(v);
  endfunction

  // q = floor(|offset| * 4 * 2^FB / size); result is -2 + signed q
  function automatic logic signed [W-1:0] map_word(input logic [W-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
    logic signed [N-1:0] v;
    v = $signed(N'(q));
    if (ovf) begin
      return neg ? WLO : WHI;
    end
    if (neg) begin
      v = -v;
    end
    v = v - TWO_N;
    return sat_n(v);
  endfunction

  function automatic pp_t part_mul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [H-1:0] a0, a1, b0, b1;
    pp_t p;
    a0 = a[H-1:0];
    a1 = H'(a[W-1:H]);
    b0 = b[H-1:0];
    b1 = H'(b[W-1:H]);
    p[0] = (2*H)'(a0) * (2*H)'(b0);
    p[1] = (2*H)'(a0) * (2*H)'(b1);
    p[2] = (2*H)'(a1) * (2*H)'(b0);
    p[3] = (2*H)'(a1) * (2*H)'(b1);
    return p;
  endfunction

  function automatic logic [2*W-1:0] join_pp(input pp_t p);
    logic [4*H-1:0] acc;
    acc = ((4*H)'(p[3]) << (2*H))
        + (((4*H)'(p[1]) + (4*H)'(p[2])) << H)
        + (4*H)'(p[0]);
    return (2*W)'(acc);
  endfunction

  logic [12:0]            px, py;
  logic signed [W-1:0]    zx, zy;
  logic signed [W-1:0]    cre, cim;
  logic signed [CW2-1:0]  cre_ext, cim_ext;
  logic [CB-1:0]          iter, iter_inc, limit;
  logic [LW-1:0]          mi_w;
  logic [W-1:0]           mx, my;
  pp_t                    pp_xx, pp_yy, pp_xy;
  logic                   xy_neg;
  logic [2*W-1:0]         sx, sy;
  logic signed [2*W-1:0]  pxy;
  logic [2*W:0]           mag2;
  logic signed [2*W:0]    diff;
  logic signed [N-1:0]    dx, dy, nx, ny;
  logic signed [13:0]     off_x, off_y;
  logic [12:0]            mag_x, mag_y, size_x, size_y;
  logic [CB+7:0]          shade_num;
  logic [7:0]             shade;
  logic [DW-1:0]          div_dividend;
  logic [VW-1:0]          div_divisor;
  logic                   div_busy, div_ovf;
  logic [W-1:0]           div_q;

  // c from Q4.28 to Q4.FB
  assign cre_ext = CW2'($signed(cfg.const_re)) <<< UP;
  assign cim_ext = CW2'($signed(cfg.const_im)) <<< UP;
  assign cre     = W'(cre_ext >>> DN);
  assign cim     = W'(cim_ext >>> DN);

  assign mi_w     = LW'(cfg.max_iterations);
  assign limit    = (mi_w < LW'(CMAX)) ? CB'(mi_w) : CMAX;
  assign iter_inc = iter + CB'(1);

  // pixel offsets and sizes
  assign off_x  = $signed({1'b0, px}) - $signed({2'b00, cfg.area_left});
  assign off_y  = $signed({1'b0, py}) - $signed({2'b00, cfg.area_top});
  assign mag_x  = off_x[13] ? 13'(-off_x) : 13'(off_x);
  assign mag_y  = off_y[13] ? 13'(-off_y) : 13'(off_y);
  assign size_x = (cfg.area_width == '0) ? 13'd1 : cfg.area_width;
  assign size_y = (cfg.area_height == '0) ? 13'd1 : cfg.area_height;

  assign shade_num = {iter, 8'd0} - (CB+8)'(iter);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_X: begin
        div_dividend = DW'({mag_x, 2'b00}) << FB;
        div_divisor  = VW'(size_x);
      end
      DIV_Y: begin
        div_dividend = DW'({mag_y, 2'b00}) << FB;
        div_divisor  = VW'(size_y);
      end
      DIV_SHADE: begin
        div_dividend = DW'(shade_num);
        div_divisor  = VW'(limit);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  jet_div #(
    .DW (DW),
    .VW (VW),
    .QW (W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q),
    .overflow (div_ovf)
  );

  // iteration step
  assign mx   = zx[W-1] ? W'(-zx) : W'(zx);
  assign my   = zy[W-1] ? W'(-zy) : W'(zy);
  assign mag2 = (2*W+1)'(sx) + (2*W+1)'(sy);
  assign diff = $signed({1'b0, sx}) - $signed({1'b0, sy});
  assign dx   = N'(diff >>> FB);
  assign dy   = N'(pxy >>> (FB - 1));
  assign nx   = dx + N'(cre);
  assign ny   = dy + N'(cim);

  assign shade = status.at_limit ? 8'd0 : div_q[7:0];

  assign status.div_busy = div_busy;
  assign status.at_limit = iter >= limit;
  assign status.escape   = mag2 >= FOUR;
  assign status.last     = iter_inc >= limit;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.store_y) begin
      iter <= '0;
    end else if (cmd.step) begin
      iter <= iter_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= in_x;
      py <= in_y;
    end
    if (cmd.store_x) begin
      zx <= map_word(div_q, div_ovf, off_x[13]);
    end else if (cmd.step) begin
      zx <= sat_n(nx);
    end
    if (cmd.store_y) begin
      zy <= map_word(div_q, div_ovf, off_y[13]);
    end else if (cmd.step) begin
      zy <= sat_n(ny);
    end
    if (cmd.mul) begin
      pp_xx  <= part_mul(mx, mx);
      pp_yy  <= part_mul(my, my);
      pp_xy  <= part_mul(mx, my);
      xy_neg <= zx[W-1] ^ zy[W-1];
    end
    if (cmd.sum) begin
      sx  <= join_pp(pp_xx);
      sy  <= join_pp(pp_yy);
      pxy <= xy_neg ? -$signed(join_pp(pp_xy)) : $signed(join_pp(pp_xy));
    end
    if (cmd.out_load) begin
      out_x     <= px;
      out_y     <= py;
      out_red   <= (cfg.color_channel == CH_RED) ? shade : 8'd0;
      out_green <= (cfg.color_channel == CH_GREEN) ? shade : 8'd0;
      out_blue  <= (cfg.color_channel == CH_BLUE) ? shade : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/jet_ctrl.sv
module jet_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jet_pkg::dp_status_t status,
  output jet_pkg::dp_cmd_t    cmd
);

  import jet_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAPX_GO,
    S_MAPX_WAIT,
    S_MAPY_GO,
    S_MAPY_WAIT,
    S_CHECK,
    S_MUL,
    S_SUM,
    S_TEST,
    S_SHADE_GO,
    S_SHADE_WAIT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MAPX_GO;
        end
      end
      S_MAPX_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_X;
        state_next    = S_MAPX_WAIT;
      end
      S_MAPX_WAIT: begin
        if (!status.div_busy) begin
          cmd.store_x = 1'b1;
          state_next  = S_MAPY_GO;
        end
      end
      S_MAPY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Y;
        state_next    = S_MAPY_WAIT;
      end
      S_MAPY_WAIT: begin
        if (!status.div_busy) begin
          cmd.store_y = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        // zero limit: no iterations at all
        state_next = status.at_limit ? S_SHADE_GO : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (status.escape) begin
          state_next = S_SHADE_GO;
        end else begin
          cmd.step   = 1'b1;
          state_next = status.last ? S_SHADE_GO : S_MUL;
        end
      end
      S_SHADE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SHADE;
        state_next    = S_SHADE_WAIT;
      end
      S_SHADE_WAIT: begin
        if (!status.div_busy && status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/julia_escape_time_pixel_top.sv
// Julia-set escape-time shader, one pixel per transaction. An input
// transaction carries a pixel position; the block maps it linearly onto the
// square -2..2 (columns on the real axis, rows on the imaginary axis, over the
// configured area), iterates z = z*z + c in signed Q4.FRACTION_BITS until
// |z|^2 reaches 4 or the count reaches the limit, and returns the position
// with a color where only the selected channel carries count*255/limit.
// Pixels that never escape, and channel selector 3, come out black.
// Timing: one pixel at a time. A result that still blocks the output
// register holds the finished pixel back until it is taken. Each iteration
// step runs partial products, then product assembly, then the escape test
// and update; the coordinate mapping and the color scaling run on one shared
// divider that resolves one quotient bit per cycle over a dividend of
// max(FRACTION_BITS+15, COUNT_BITS+8) bits (43 by default). The next pixel is
// accepted while a finished result still waits in the output register.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module julia_escape_time_pixel_top #(
  parameter int FRACTION_BITS = 28,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [12:0] pixel_x, [25:13] pixel_y, rest zero
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [12:0] out_x, [25:13] out_y, [33:26] red,
                                 // [41:34] green, [49:42] blue, rest zero
  // register write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import jet_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [12:0] out_x, out_y;
  logic [7:0]  out_red, out_green, out_blue;

  // Configuration registers; each write keeps the low bits of the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.area_left      <= '0;
      cfg.area_top       <= '0;
      cfg.area_width     <= AREA_WIDTH_RESET;
      cfg.area_height    <= AREA_HEIGHT_RESET;
      cfg.const_re       <= CONST_RE_RESET;
      cfg.const_im       <= CONST_IM_RESET;
      cfg.max_iterations <= MAX_ITER_RESET;
      cfg.color_channel  <= CH_RED;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AREA_LEFT:      cfg.area_left      <= cfg_data[11:0];
        REG_AREA_TOP:       cfg.area_top       <= cfg_data[11:0];
        REG_AREA_WIDTH:     cfg.area_width     <= cfg_data[12:0];
        REG_AREA_HEIGHT:    cfg.area_height    <= cfg_data[12:0];
        REG_CONST_RE:       cfg.const_re       <= cfg_data;
        REG_CONST_IM:       cfg.const_im       <= cfg_data;
        REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[15:0];
        REG_COLOR_CHANNEL:  cfg.color_channel  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: mapping, step loop, color scaling, output handoff.
  jet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: coordinate map, complex step, divider and output register.
  jet_datapath #(
    .FB (FRACTION_BITS),
    .CB (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_x      (s_tdata[12:0]),
    .in_y      (s_tdata[25:13]),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  assign m_tdata = {6'd0, out_blue, out_green, out_red, out_y, out_x};

endmodule

FILE: hdl/jet_checker.sv
module jet_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // one pixel at a time: input closes right after a transaction
  a_in_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after a transaction");

  // a result never appears the cycle after a pixel was taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result raised too early after input transaction");

  // at most one color channel lit
  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({|m_tdata[49:42], |m_tdata[41:34], |m_tdata[33:26]}))
    else $error("more than one color channel nonzero");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind julia_escape_time_pixel_top jet_checker u_checker (.*);
